### hw/rtl/rpu_pkg.sv
// Shared types and constants for the RMSProp parameter update block.
// No dependencies; imported by the top level, the checker and the testbench.
package rpu_pkg;

  // Fixed field widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned SlotW  = 12;
  localparam int unsigned DecayW = 16;
  localparam int unsigned CoefW  = 31;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DECAY   = 2'd0,
    CFG_EPSILON = 2'd1,
    CFG_RATE    = 2'd2
  } cfg_idx_e;

  // Register reset values
  localparam logic [DecayW-1:0] DecayRst = 16'd58982;
  localparam logic [CoefW-1:0]  EpsRst   = 31'd1;
  localparam logic [CoefW-1:0]  RateRst  = 31'd167772;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PROD,
    S_ACC,
    S_SQR,
    S_MOD,
    S_RD,
    S_EMUL,
    S_EADD,
    S_SQRT,
    S_DIV,
    S_FIN
  } state_e;

endpackage

### hw/rtl/rpu_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on nothing but the clock and reset.
module rpu_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // Bring down two radicand bits and try the next root bit
  assign rem_sh = {rem_q[33:0], rad_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

### hw/rtl/rpu_div.sv
// Restoring divider, 63-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on nothing but the clock and reset.
module rpu_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [62:0] quo_o
);

  logic [62:0] num_q;
  logic [62:0] quo_q;
  logic [31:0] den_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [32:0] rem_sh;

  // Shift in the next dividend bit
  assign rem_sh = {rem_q, num_q[62]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd62) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[61:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= 32'(rem_sh - {1'b0, den_q});
        quo_q <= {quo_q[61:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[61:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/rmsprop_parameter_update.sv
// RMSProp parameter update. One transaction is accepted at a time. An item
// that is not marked last passes through register, multiply and accumulate.
// An item marked last then goes on through the gradient square, the slot
// reduction, the second-moment read-modify-write, the bit-serial square
// root and the bit-serial divider, then hands the result to the output
// register, waiting there while a held output is stalled.
// After reset the second-moment memory is swept clear, during which
// in_stall_o stays high; configuration writes are taken at any time.
module rmsprop_parameter_update #(
  parameter int unsigned SLOTS     = 4096,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpu_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rpu_pkg::CoefW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            error_term_i,
  input  logic signed [31:0]            activation_i,
  input  logic [rpu_pkg::SlotW-1:0]     slot_i,
  input  logic signed [31:0]            old_weight_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            new_weight_o,
  output logic [rpu_pkg::SlotW-1:0]     slot_out_o
);
  import rpu_pkg::*;

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  state_e state_q, state_d;

  // Configuration registers
  logic [DecayW-1:0] decay_q;
  logic [CoefW-1:0]  eps_q;
  logic [CoefW-1:0]  rate_q;

  // Item and datapath registers
  logic signed [31:0] e_q, a_q, w_q;
  logic [SlotW-1:0]   slot_q;
  logic               last_q;
  logic signed [63:0] prod_q;
  logic signed [63:0] sum_q;
  logic               gneg_q;
  logic [31:0]        mag_q;
  logic [31:0]        g2_q;
  logic [SlotW-1:0]   r_q;
  logic [3:0]         k_q;
  logic [AW-1:0]      idx_q;
  logic [AW-1:0]      clr_q;
  logic [31:0]        rdata_q;
  logic [47:0]        p1_q;
  logic [48:0]        p2_q;
  logic               out_valid_q;
  logic signed [31:0] nw_q;
  logic [SlotW-1:0]   slot_out_q;

  logic [31:0] mem_q [SLOTS];

  // Combinational datapath
  logic signed [64:0] sum_wide;
  logic signed [63:0] sum_d;
  logic signed [63:0] g_shift;
  logic signed [31:0] g_sat;
  logic [63:0]        sq;
  logic [63:0]        sq_sh;
  logic [32:0]        mod_cmp;
  logic [49:0]        e_sum;
  logic [49:0]        e_sh;
  logic [31:0]        en;
  logic               sqrt_done, div_done;
  logic [31:0]        root;
  logic [62:0]        quo;
  logic [31:0]        den_raw, den;
  logic [62:0]        num;
  logic signed [65:0] nw_wide;
  logic signed [31:0] nw_sat;
  logic               fin_go;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [31:0]        mem_wdata;

  // Saturating gradient accumulate
  always_comb begin
    sum_wide = 65'(sum_q) + 65'(prod_q);
    if (sum_wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
      sum_d = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (sum_wide < -65'sh0_8000_0000_0000_0000) begin
      sum_d = 64'sh8000_0000_0000_0000;
    end else begin
      sum_d = sum_wide[63:0];
    end
    g_shift = sum_d >>> FRAC_BITS;
    if (g_shift > 64'sh0000_0000_7FFF_FFFF) begin
      g_sat = 32'sh7FFF_FFFF;
    end else if (g_shift < -64'sh0000_0000_8000_0000) begin
      g_sat = 32'sh8000_0000;
    end else begin
      g_sat = g_shift[31:0];
    end
  end

  // Gradient square, reduced and saturated
  assign sq    = 64'(mag_q) * 64'(mag_q);
  assign sq_sh = sq >> FRAC_BITS;

  // Slot reduction step against SLOTS shifted by the step count
  assign mod_cmp = 33'(SLOTS) << k_q;

  // Second-moment blend with rounding
  assign e_sum = 50'(p1_q) + 50'(p2_q) + 50'd32768;
  assign e_sh  = e_sum >> 16;
  assign en    = (|e_sh[49:32]) ? 32'hFFFF_FFFF : e_sh[31:0];

  // Divisor and dividend for the step
  assign den_raw = 32'(root) + 32'(eps_q);
  assign den     = (den_raw == 32'd0) ? 32'd1 : den_raw;
  assign num     = 63'(rate_q) * 63'(mag_q);

  // Apply the signed step and saturate
  always_comb begin
    nw_wide = gneg_q ? (66'(w_q) + $signed({3'b000, quo}))
                     : (66'(w_q) - $signed({3'b000, quo}));
    if (nw_wide > 66'sh0_7FFF_FFFF) begin
      nw_sat = 32'sh7FFF_FFFF;
    end else if (nw_wide < -66'sh0_8000_0000) begin
      nw_sat = 32'sh8000_0000;
    end else begin
      nw_sat = nw_wide[31:0];
    end
  end

  assign fin_go = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(SLOTS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_PROD;
      S_PROD:  state_d = S_ACC;
      S_ACC:   state_d = last_q ? S_SQR : S_IDLE;
      S_SQR:   state_d = S_MOD;
      S_MOD:   if (k_q == 4'd0) state_d = S_RD;
      S_RD:    state_d = S_EMUL;
      S_EMUL:  state_d = S_EADD;
      S_EADD:  state_d = S_SQRT;
      S_SQRT:  if (sqrt_done) state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_FIN;
      S_FIN:   if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Write configuration registers; ignore indexes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DecayRst;
      eps_q   <= EpsRst;
      rate_q  <= RateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DECAY:   decay_q <= cfg_data_i[DecayW-1:0];
        CFG_EPSILON: eps_q   <= cfg_data_i;
        CFG_RATE:    rate_q  <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Control registers: clear sweep, gradient sum, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_ACC) sum_q <= last_q ? 64'sd0 : sum_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        e_q    <= error_term_i;
        a_q    <= activation_i;
        slot_q <= slot_i;
        w_q    <= old_weight_i;
        last_q <= last_i;
      end
      S_PROD: prod_q <= e_q * a_q;
      S_ACC: begin
        gneg_q <= g_sat[31];
        mag_q  <= g_sat[31] ? 32'(-33'(g_sat)) : g_sat;
        r_q    <= slot_q;
        k_q    <= 4'd11;
      end
      S_SQR: g2_q <= (|sq_sh[63:32]) ? 32'hFFFF_FFFF : sq_sh[31:0];
      S_MOD: begin
        if (33'(r_q) >= mod_cmp) r_q <= r_q - mod_cmp[SlotW-1:0];
        k_q <= k_q - 4'd1;
      end
      S_RD: idx_q <= AW'(r_q);
      S_EMUL: begin
        p1_q <= 48'(decay_q) * 48'(rdata_q);
        p2_q <= (49'(17'h10000) - 49'(decay_q)) * 49'(g2_q);
      end
      S_FIN: if (fin_go) begin
        nw_q       <= nw_sat;
        slot_out_q <= slot_q;
      end
      default: ;
    endcase
  end

  // Memory write port: clear sweep or second-moment update
  always_comb begin
    mem_we    = (state_q == S_CLEAR) || (state_q == S_EADD);
    mem_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
    mem_wdata = (state_q == S_CLEAR) ? 32'd0 : en;
  end

  // Read at the reduced slot so the entry is ready for the blend
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= mem_q[AW'(r_q)];
  end

  rpu_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(state_q == S_EADD),
    .rad_i  (64'(en) << FRAC_BITS),
    .done_o (sqrt_done),
    .root_o (root)
  );

  rpu_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sqrt_done),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign new_weight_o = nw_q;
  assign slot_out_o   = slot_out_q;

  // Hold off items while the memory is swept
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o) else $error("item taken during clear");

  // Unit completions land only in their waiting states
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> (state_q == S_SQRT)) else $error("stray sqrt done");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV)) else $error("stray div done");

  // Gradient sum restarts after every update
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && last_q) |=> (sum_q == 64'sd0)) else $error("sum kept");

endmodule

### test/rmsprop_parameter_update_checker.sv
// Checker for the RMSProp parameter update block: mirrors the register file,
// predicts each weight update and compares it with the output channel.
// Depends on rpu_pkg for the register indexes and field widths.
module rmsprop_parameter_update_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpu_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpu_pkg::CoefW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic signed [31:0]          error_term_i,
  input  logic signed [31:0]          activation_i,
  input  logic [rpu_pkg::SlotW-1:0]   slot_i,
  input  logic signed [31:0]          old_weight_i,
  input  logic                        last_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic signed [31:0]          new_weight_i,
  input  logic [rpu_pkg::SlotW-1:0]   slot_out_i,
  output int                          pending_o,
  output int                          errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rpu_pkg::*;

  localparam int unsigned FracBits = 24;

  typedef struct packed {
    logic signed [31:0]  weight;
    logic [SlotW-1:0]    slot;
  } update_t;

  logic [31:0]        moment_mem [4096];
  logic signed [63:0] grad_acc;
  logic [DecayW-1:0]  decay_q;
  logic [CoefW-1:0]   eps_q;
  logic [CoefW-1:0]   rate_q;
  update_t            updates_q [$];

  assign pending_o = updates_q.size();

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] v, r, b;
    v = x;
    r = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] clip32(input logic signed [63:0] v);
    if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Accumulate one product; on the closing transaction compute the update
  task automatic absorb_item();
    logic signed [63:0] prod, s, g, step, nw;
    logic signed [64:0] wide;
    logic [63:0]        mag, g2, en, den, num, q;
    prod = 64'(error_term_i) * 64'(activation_i);
    wide = {grad_acc[63], grad_acc} + {prod[63], prod};
    if (wide[64] != wide[63]) begin
      grad_acc = wide[64] ? {1'b1, 63'h0} : {1'b0, {63{1'b1}}};
    end else begin
      grad_acc = wide[63:0];
    end
    if (!last_i) return;
    s = grad_acc;
    grad_acc = '0;
    g = clip32(s >>> FracBits);
    mag = (g < 0) ? -g : g;
    g2 = (mag * mag) >> FracBits;
    if (g2 > 64'hffff_ffff) g2 = 64'hffff_ffff;
    en = 64'(decay_q) * 64'(moment_mem[slot_i]) + (64'd65536 - 64'(decay_q)) * g2 + 64'd32768;
    en = en >> 16;
    if (en > 64'hffff_ffff) en = 64'hffff_ffff;
    moment_mem[slot_i] = en[31:0];
    den = floor_root(en << FracBits) + 64'(eps_q);
    if (den == 0) den = 64'd1;
    num = 64'(rate_q) * mag;
    q = num / den;
    step = (g < 0) ? -$signed(q) : $signed(q);
    nw = clip32(64'(old_weight_i) - step);
    updates_q.push_back('{weight: nw[31:0], slot: slot_i});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (moment_mem[i]) moment_mem[i] = '0;
      grad_acc = '0;
      decay_q  = DecayRst;
      eps_q    = EpsRst;
      rate_q   = RateRst;
      updates_q.delete();
      errors_o = 0;
    end else begin
      // Track register writes; unused indexes are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_DECAY:   decay_q = cfg_data_i[DecayW-1:0];
          CFG_EPSILON: eps_q   = cfg_data_i;
          CFG_RATE:    rate_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_item();
      // Compare each delivered update with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (updates_q.size() == 0) begin
          $error("unexpected update: new_weight %0d slot_out %0d", new_weight_i, slot_out_i);
          errors_o++;
        end else begin
          update_t exp_upd;
          exp_upd = updates_q.pop_front();
          if (new_weight_i !== exp_upd.weight) begin
            $error("new_weight expected %0d actual %0d", exp_upd.weight, new_weight_i);
            errors_o++;
          end
          if (slot_out_i !== exp_upd.slot) begin
            $error("slot_out expected %0d actual %0d", exp_upd.slot, slot_out_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

### test/rmsprop_parameter_update_tb.sv
// Top of the RMSProp parameter update testbench: clock, reset, stimulus and
// verdict. Depends on rpu_pkg, the block and rmsprop_parameter_update_checker.
module rmsprop_parameter_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpu_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam int                 CycleLimit = 1_500_000;
  localparam int                 SettleCycles = 150;
  localparam logic signed [31:0] QOne = 32'sh0100_0000;
  localparam logic signed [31:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMin = 32'sh8000_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CoefW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] error_term = '0;
  logic signed [31:0] activation = '0;
  logic [SlotW-1:0]   slot = '0;
  logic signed [31:0] old_weight = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] new_weight;
  logic [SlotW-1:0]   slot_out;
  int                 pending;
  int                 errors;
  int                 cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;

  always #6 clk_i = ~clk_i;

  rmsprop_parameter_update uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .error_term_i(error_term), .activation_i(activation), .slot_i(slot),
    .old_weight_i(old_weight), .last_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .new_weight_o(new_weight), .slot_out_o(slot_out)
  );

  rmsprop_parameter_update_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .error_term_i(error_term), .activation_i(activation), .slot_i(slot),
    .old_weight_i(old_weight), .last_i(last),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .new_weight_i(new_weight), .slot_out_i(slot_out),
    .pending_o(pending), .errors_o(errors)
  );

  // Stall the output side at random
  always @(posedge clk_i) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Offer one transaction after an optional random gap, hold until taken
  task automatic send_item(input logic signed [31:0] e, input logic signed [31:0] a,
                           input logic [SlotW-1:0] s, input logic signed [31:0] w,
                           input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    error_term <= e;
    activation <= a;
    slot       <= s;
    old_weight <= w;
    last       <= l;
    @(negedge clk_i);
    while (in_stall) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Drop valid and wait until every predicted update has come out
  task automatic drain();
    @(posedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_q();
    if ($urandom_range(99) < 15) return $urandom;
    return $signed($urandom_range(33554431)) - QOne;
  endfunction

  function automatic logic [SlotW-1:0] pick_slot();
    if ($urandom_range(1)) return SlotW'($urandom_range(15));
    return SlotW'($urandom_range(4095));
  endfunction

  initial begin
    int sent;
    int len;
    int phase;
    logic signed [31:0] act;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, saturation, bias, zero and tiny gradients, windows
    send_item(QMax, QMax, 12'd0, 32'sd0, 1'b1);
    send_item(QMin, QMin, 12'd4095, 32'sd0, 1'b0);
    send_item(QMin, QMin, 12'd4095, QMin, 1'b1);
    send_item(QMin, QMax, 12'd1, QMax, 1'b1);
    send_item(QMax, QMin, 12'd4094, QMin, 1'b1);
    send_item(QOne, QOne, 12'd2, 32'sh0080_0000, 1'b1);
    send_item(32'sd0, QMax, 12'd3, QMax, 1'b1);
    send_item(pick_q(), pick_q(), 12'd9, 32'sd0, 1'b0);
    send_item(pick_q(), pick_q(), 12'd9, 32'sd0, 1'b0);
    send_item(pick_q(), pick_q(), 12'd5, 32'sh1234_5678, 1'b1);
    send_item(32'sh1000, 32'sh1000, 12'd6, 32'sd0, 1'b1);
    drain();

    // Zero denominator: epsilon cleared, fresh slots with tiny and zero gradients
    write_reg(CfgUnused, 31'h7fff_ffff);
    write_reg(CFG_EPSILON, 31'd0);
    send_item(32'sh1000, 32'sh1000, 12'd7, 32'sd0, 1'b1);
    send_item(32'sd0, 32'sd0, 12'd8, QMin, 1'b1);
    send_item(32'sh1000, 32'sh1000, 12'd10, QMax, 1'b1);
    drain();

    // Random phases; each starts idle with a new register setting
    sent = 0;
    for (phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 35 : (phase < 4) ? 80 : 0;
      recv_idle_pct = (phase < 2) ? 80 : (phase < 4) ? 35 : 0;
      case (phase)
        0: begin
          write_reg(CFG_DECAY, 31'd65535);
          write_reg(CFG_EPSILON, 31'h7fff_ffff);
          write_reg(CFG_RATE, 31'h7fff_ffff);
        end
        1: begin
          write_reg(CFG_DECAY, 31'd0);
          write_reg(CFG_EPSILON, 31'd0);
          write_reg(CFG_RATE, 31'd0);
        end
        2: begin
          write_reg(CFG_DECAY, 31'(DecayRst));
          write_reg(CFG_EPSILON, 31'(EpsRst));
          write_reg(CFG_RATE, 31'(RateRst));
        end
        default: begin
          write_reg(CFG_DECAY, 31'($urandom_range(65535)));
          write_reg(CFG_EPSILON, 31'($urandom_range(1 << 20)));
          write_reg(CFG_RATE, 31'($urandom));
        end
      endcase
      while (sent < (phase + 1) * 125) begin
        len = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          act = ($urandom_range(4) == 0) ? QOne : pick_q();
          send_item(pick_q(), act, pick_slot(), pick_q(), k == len - 1);
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
